// ===== hw/rtl/bts_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and sizing helpers for the bilinear texture sampler.
package bts_pkg;

  localparam int unsigned TEX_DIM_DEF   = 256;
  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned WR_IDX_W   = 8;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned TEXEL_W    = NUM_CHAN * CHAN_W;
  localparam int unsigned NUM_BANKS  = 4;
  localparam int unsigned BANK_SEL_W = 2;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic rd_valid;
    logic lerp_valid;
  } back_stat_t;

  // Texels are split over four banks by (row parity, column parity).
  function automatic int unsigned half_dim(int unsigned dim);
    return (dim + 1) >> 1;
  endfunction

  function automatic int unsigned bank_depth(int unsigned dim);
    int unsigned h;
    h = half_dim(dim);
    return h * h;
  endfunction

  function automatic int unsigned bank_addr_w(int unsigned dim);
    int unsigned d;
    d = bank_depth(dim);
    return (d > 1) ? $clog2(d) : 1;
  endfunction

  function automatic int unsigned half_idx_w(int unsigned dim);
    int unsigned h;
    h = half_dim(dim);
    return (h > 1) ? $clog2(h) : 1;
  endfunction

endpackage

// ===== hw/rtl/bts_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies each word and turns coordinates into bank addresses.
module bts_front #(
  parameter int unsigned TEX_DIM   = bts_pkg::TEX_DIM_DEF,
  parameter int unsigned FRAC_BITS = bts_pkg::FRAC_BITS_DEF,
  parameter type         entry_t   = logic
) (
  input  bts_pkg::op_e                      operation_i,
  input  logic [bts_pkg::COORD_W-1:0]       u_coord_i,
  input  logic [bts_pkg::COORD_W-1:0]       v_coord_i,
  input  logic [bts_pkg::WR_IDX_W-1:0]      write_x_i,
  input  logic [bts_pkg::WR_IDX_W-1:0]      write_y_i,
  input  logic [bts_pkg::CHAN_W-1:0]        texel_red_i,
  input  logic [bts_pkg::CHAN_W-1:0]        texel_green_i,
  input  logic [bts_pkg::CHAN_W-1:0]        texel_blue_i,
  output entry_t                            entry_o
);
  import bts_pkg::*;

  localparam int unsigned IDX_W = $clog2(TEX_DIM);
  localparam int unsigned HALF  = half_dim(TEX_DIM);
  localparam int unsigned HW    = half_idx_w(TEX_DIM);
  localparam int unsigned AW    = bank_addr_w(TEX_DIM);

  localparam logic [COORD_W-1:0] LAST     = COORD_W'(TEX_DIM - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TEX_DIM - 1);

  logic [COORD_W-1:0] xi, yi;
  logic [IDX_W-1:0]   x0, y0;
  logic               x_edge, y_edge;
  logic [HW-1:0]      col_even, col_odd, row_even, row_odd;
  logic [AW-1:0]      base_even, base_odd;
  logic               wr_in_range;

  always_comb begin
    xi = u_coord_i >> FRAC_BITS;
    yi = v_coord_i >> FRAC_BITS;
    x0 = (xi > LAST) ? LAST_IDX : IDX_W'(xi);
    y0 = (yi > LAST) ? LAST_IDX : IDX_W'(yi);
    // at the last texel the neighbour is the texel itself
    x_edge = (x0 == LAST_IDX);
    y_edge = (y0 == LAST_IDX);

    // even bank holds whichever of floor/floor+1 is even, same for odd
    col_even = x_edge ? HW'(x0 >> 1) : HW'(({1'b0, x0} + 1'b1) >> 1);
    col_odd  = HW'(x0 >> 1);
    row_even = y_edge ? HW'(y0 >> 1) : HW'(({1'b0, y0} + 1'b1) >> 1);
    row_odd  = HW'(y0 >> 1);

    base_even = AW'(row_even) * AW'(HALF);
    base_odd  = AW'(row_odd) * AW'(HALF);

    wr_in_range = (32'(write_x_i) < TEX_DIM) && (32'(write_y_i) < TEX_DIM);

    entry_o.smp     = (operation_i == OP_SAMPLE);
    entry_o.wr_en   = (operation_i == OP_WRITE) && wr_in_range;
    entry_o.wr_bank = {write_y_i[0], write_x_i[0]};
    entry_o.wr_addr = AW'(write_y_i >> 1) * AW'(HALF) + AW'(write_x_i >> 1);
    entry_o.wr_data = {texel_red_i, texel_green_i, texel_blue_i};
    for (int b = 0; b < NUM_BANKS; b++) begin
      entry_o.rd_addr[b] = (b[1] ? base_odd : base_even)
                         + AW'(b[0] ? col_odd : col_even);
    end
    entry_o.px0    = x0[0];
    entry_o.py0    = y0[0];
    entry_o.x_edge = x_edge;
    entry_o.y_edge = y_edge;
    entry_o.fx     = u_coord_i[FRAC_BITS-1:0];
    entry_o.fy     = v_coord_i[FRAC_BITS-1:0];
  end

endmodule

// ===== hw/rtl/bts_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO of decoded words between front and back end.
module bts_queue #(
  parameter type entry_t = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  entry_t           data_i,
  input  logic             pop_i,
  output entry_t           data_o,
  output bts_pkg::q_stat_t stat_o
);
  import bts_pkg::*;

  entry_t             slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

// ===== hw/rtl/bts_back.sv =====
`timescale 1ns / 1ps
// Back end: banked texel store, 2x2 fetch, horizontal then vertical blend.
module bts_back #(
  parameter int unsigned TEX_DIM   = bts_pkg::TEX_DIM_DEF,
  parameter int unsigned FRAC_BITS = bts_pkg::FRAC_BITS_DEF,
  parameter type         entry_t   = logic
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  entry_t                      head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bts_pkg::CHAN_W-1:0]  red_o,
  output logic [bts_pkg::CHAN_W-1:0]  green_o,
  output logic [bts_pkg::CHAN_W-1:0]  blue_o,
  output bts_pkg::back_stat_t         stat_o
);
  import bts_pkg::*;

  localparam int unsigned BANK_DEPTH = bank_depth(TEX_DIM);
  localparam int unsigned WT_W       = FRAC_BITS + 1;
  localparam int unsigned LERP_W     = CHAN_W + FRAC_BITS;
  localparam int unsigned SUM_W      = CHAN_W + 2 * FRAC_BITS;

  localparam logic [WT_W-1:0]  ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (2 * FRAC_BITS - 1);

  logic o_ready, l_ready, r_ready;
  logic rd_en, wr_en;

  // texel banks and their registered read data
  logic [TEXEL_W-1:0] tex_mem_q [NUM_BANKS][BANK_DEPTH];
  logic [TEXEL_W-1:0] rdata_q [NUM_BANKS];

  // fetch stage
  logic                 rd_valid_q, rd_valid_d;
  logic                 r_px0_q, r_py0_q, r_xe_q, r_ye_q;
  logic [FRAC_BITS-1:0] r_fx_q, r_fy_q;

  // horizontal blend stage
  logic                                lerp_valid_q, lerp_valid_d;
  logic [NUM_CHAN-1:0][LERP_W-1:0]     l_top_q, l_top_d, l_bot_q, l_bot_d;
  logic [FRAC_BITS-1:0]                l_fy_q;

  // output stage
  logic                                out_valid_q, out_valid_d;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]     res_q, res_d;

  logic [TEXEL_W-1:0] t00, t10, t01, t11;
  logic               x1_par, y1_par;
  logic [WT_W-1:0]    wx0, wx1, wy0, wy1;
  logic [SUM_W-1:0]   vsum;

  always_comb begin
    o_ready = !out_valid_q || !out_stall_i;
    l_ready = !lerp_valid_q || o_ready;
    r_ready = !rd_valid_q || l_ready;
    // writes retire at the memory and need no room downstream
    pop_o   = head_valid_i && (!head_i.smp || r_ready);
    rd_en   = pop_o && head_i.smp;
    wr_en   = pop_o && head_i.wr_en;
    rd_valid_d = r_ready ? rd_en : rd_valid_q;
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (wr_en && (head_i.wr_bank == BANK_SEL_W'(b))) begin
        tex_mem_q[b][head_i.wr_addr] <= head_i.wr_data;
      end
      if (rd_en) begin
        rdata_q[b] <= tex_mem_q[b][head_i.rd_addr[b]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      r_px0_q <= head_i.px0;
      r_py0_q <= head_i.py0;
      r_xe_q  <= head_i.x_edge;
      r_ye_q  <= head_i.y_edge;
      r_fx_q  <= head_i.fx;
      r_fy_q  <= head_i.fy;
    end
  end

  // route bank data to the 2x2 corners, edge collapses onto floor texel
  always_comb begin
    x1_par = r_xe_q ? r_px0_q : !r_px0_q;
    y1_par = r_ye_q ? r_py0_q : !r_py0_q;
    t00 = rdata_q[{r_py0_q, r_px0_q}];
    t10 = rdata_q[{r_py0_q, x1_par}];
    t01 = rdata_q[{y1_par, r_px0_q}];
    t11 = rdata_q[{y1_par, x1_par}];
    wx1 = {1'b0, r_fx_q};
    wx0 = ONE - wx1;
    for (int c = 0; c < NUM_CHAN; c++) begin
      l_top_d[c] = LERP_W'(t00[c*CHAN_W +: CHAN_W]) * LERP_W'(wx0)
                 + LERP_W'(t10[c*CHAN_W +: CHAN_W]) * LERP_W'(wx1);
      l_bot_d[c] = LERP_W'(t01[c*CHAN_W +: CHAN_W]) * LERP_W'(wx0)
                 + LERP_W'(t11[c*CHAN_W +: CHAN_W]) * LERP_W'(wx1);
    end
    lerp_valid_d = l_ready ? rd_valid_q : lerp_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (l_ready && rd_valid_q) begin
      l_top_q <= l_top_d;
      l_bot_q <= l_bot_d;
      l_fy_q  <= r_fy_q;
    end
  end

  always_comb begin
    wy1  = {1'b0, l_fy_q};
    wy0  = ONE - wy1;
    vsum = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      vsum = SUM_W'(l_top_q[c]) * SUM_W'(wy0) + SUM_W'(l_bot_q[c]) * SUM_W'(wy1) + RND;
      res_d[c] = vsum[2*FRAC_BITS +: CHAN_W];
    end
    out_valid_d = o_ready ? lerp_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && lerp_valid_q) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q   <= 1'b0;
      lerp_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_valid_q   <= rd_valid_d;
      lerp_valid_q <= lerp_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign red_o             = res_q[2];
  assign green_o           = res_q[1];
  assign blue_o            = res_q[0];
  assign stat_o.rd_valid   = rd_valid_q;
  assign stat_o.lerp_valid = lerp_valid_q;

endmodule

// ===== hw/rtl/bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
// Bilinear texture sampler top level: front decode, word queue, banked back end.
//
// Input channel (in_valid_i / in_stall_o) carries one word: a texel write
// (operation_i = write, write_x_i/write_y_i, texel_*_i) or a sample request
// (u_coord_i/v_coord_i, FRAC_BITS fraction bits). Writes outside the texture
// are dropped; writes produce no output word.
// Output channel (out_valid_o / out_stall_i) returns red/green/blue for each
// sample, in request order, rounded half up.
// Path: a sample accepted into the queue goes through the bank read, the
// horizontal blend and the vertical blend registers to the outputs.
// Throughput: one word per cycle without output stalls. The texture sits in
// four banks by row and column parity, so the 2x2 footprint is one read per
// bank per cycle. Stalls: out_stall_i backs up the blend stages, then the
// four-entry queue; in_stall_o is high exactly while the queue is full.
// Reset clears all valid state; texel contents are undefined until written.
module bilinear_texture_sampler #(
  parameter int unsigned TEX_DIM   = bts_pkg::TEX_DIM_DEF,
  parameter int unsigned FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bts_pkg::op_e                operation_i,
  input  logic [bts_pkg::COORD_W-1:0] u_coord_i,
  input  logic [bts_pkg::COORD_W-1:0] v_coord_i,
  input  logic [bts_pkg::WR_IDX_W-1:0] write_x_i,
  input  logic [bts_pkg::WR_IDX_W-1:0] write_y_i,
  input  logic [bts_pkg::CHAN_W-1:0]  texel_red_i,
  input  logic [bts_pkg::CHAN_W-1:0]  texel_green_i,
  input  logic [bts_pkg::CHAN_W-1:0]  texel_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bts_pkg::CHAN_W-1:0]  red_o,
  output logic [bts_pkg::CHAN_W-1:0]  green_o,
  output logic [bts_pkg::CHAN_W-1:0]  blue_o
);
  import bts_pkg::*;

  localparam int unsigned AW = bank_addr_w(TEX_DIM);

  // decoded word as it travels from front to back
  typedef struct packed {
    logic                           smp;
    logic                           wr_en;
    logic [BANK_SEL_W-1:0]          wr_bank;
    logic [AW-1:0]                  wr_addr;
    logic [TEXEL_W-1:0]             wr_data;
    logic [NUM_BANKS-1:0][AW-1:0]   rd_addr;
    logic                           px0;
    logic                           py0;
    logic                           x_edge;
    logic                           y_edge;
    logic [FRAC_BITS-1:0]           fx;
    logic [FRAC_BITS-1:0]           fy;
  } entry_t;

  entry_t     front_entry, head;
  q_stat_t    q_stat;
  back_stat_t back_stat;
  logic       q_push, q_pop;

  assign in_stall_o = q_stat.full;
  assign q_push     = in_valid_i && !q_stat.full;

  bts_front #(
    .TEX_DIM   (TEX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .entry_t   (entry_t)
  ) u_front (
    .operation_i   (operation_i),
    .u_coord_i     (u_coord_i),
    .v_coord_i     (v_coord_i),
    .write_x_i     (write_x_i),
    .write_y_i     (write_y_i),
    .texel_red_i   (texel_red_i),
    .texel_green_i (texel_green_i),
    .texel_blue_i  (texel_blue_i),
    .entry_o       (front_entry)
  );

  bts_queue #(
    .entry_t (entry_t)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_entry),
    .pop_i  (q_pop),
    .data_o (head),
    .stat_o (q_stat)
  );

  bts_back #(
    .TEX_DIM   (TEX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .entry_t   (entry_t)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_stat.empty),
    .head_i       (head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .stat_o       (back_stat)
  );

  // back end only drains a queue that holds something
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // a lone push grows the queue by exactly one word
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count lost a pushed word");

  // a new result only comes from the blend stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_stat.lerp_valid))
    else $error("result appeared without a blended word");

  // an empty output register never holds back a blended word
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_stat.lerp_valid && !out_valid_o) |=> out_valid_o)
    else $error("blended word did not reach the output");

endmodule

// ===== bench/bilinear_texture_sampler_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the bilinear texture sampler: directed table, then random words.
module bilinear_texture_sampler_tb;
  import bts_pkg::*;

  localparam int unsigned DIM            = TEX_DIM_DEF;
  localparam int unsigned FRAC           = FRAC_BITS_DEF;
  localparam int unsigned ONE            = 1 << FRAC;
  localparam int unsigned IDLE_PCT       = 14;
  localparam int unsigned TOTAL_WORDS    = 1200;
  localparam int unsigned DRAIN_CYCLES   = 8;     // margin for results still in the pipeline
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PRINT_CAP      = 100;
  localparam int unsigned DIR_ROWS       = 21;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // One input word as the block sees it.
  typedef struct packed {
    op_e                 op;
    logic [COORD_W-1:0]  u;
    logic [COORD_W-1:0]  v;
    logic [WR_IDX_W-1:0] wx;
    logic [WR_IDX_W-1:0] wy;
    rgb_t                color;
  } tex_word_t;

  // Directed row: the word, and a typed-in filtered color where it is obvious.
  typedef struct packed {
    tex_word_t word;
    logic      known;
    rgb_t      want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall_o;
  op_e                 operation   = OP_SAMPLE;
  logic [COORD_W-1:0]  u_coord     = '0;
  logic [COORD_W-1:0]  v_coord     = '0;
  logic [WR_IDX_W-1:0] write_x     = '0;
  logic [WR_IDX_W-1:0] write_y     = '0;
  logic [CHAN_W-1:0]   texel_red   = '0;
  logic [CHAN_W-1:0]   texel_green = '0;
  logic [CHAN_W-1:0]   texel_blue  = '0;
  logic                out_valid_o;
  logic                out_stall   = 1'b0;
  logic [CHAN_W-1:0]   red_o;
  logic [CHAN_W-1:0]   green_o;
  logic [CHAN_W-1:0]   blue_o;

  // Shadow texture and the set of texels written so far. Samples only
  // touch footprints whose four texels are all in the written set.
  rgb_t        texel_mem     [DIM*DIM];
  bit          texel_written [DIM*DIM];
  rgb_t        filtered_fifo [$];   // filtered colors still owed by the block
  rgb_t        head_rgb;
  int unsigned words_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  bit          steady         = 1'b0;  // no idling on either side while set
  int unsigned last_x         = 0;
  int unsigned last_y         = 0;

  // Writes first: a 2x2 block at the origin and at the far corner. Samples
  // with zero fraction (or clamped to the corner) read one texel exactly.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd0,   8'd0,   24'hFF0080}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd1,   8'd0,   24'h00FF7F}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd0,   8'd1,   24'h123456}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd1,   8'd1,   24'hEDCBA9}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd254, 8'd254, 24'h010203}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd255, 8'd254, 24'hFEFDFC}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd254, 8'd255, 24'h808080}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd255, 8'd255, 24'h7F00FF}, 1'b0, 24'h0},
    '{'{OP_SAMPLE, 16'h0000, 16'h0000, 8'd0,   8'd0,   24'h000000}, 1'b1, 24'hFF0080},
    '{'{OP_SAMPLE, 16'h0080, 16'h0000, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h0},
    '{'{OP_SAMPLE, 16'h00FF, 16'h00FF, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h0},
    '{'{OP_SAMPLE, 16'h0080, 16'h0080, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h0},
    '{'{OP_SAMPLE, 16'hFF00, 16'hFF00, 8'd0,   8'd0,   24'h000000}, 1'b1, 24'h7F00FF},
    '{'{OP_SAMPLE, 16'hFFFF, 16'hFFFF, 8'd0,   8'd0,   24'h000000}, 1'b1, 24'h7F00FF},
    '{'{OP_SAMPLE, 16'hFE00, 16'hFE00, 8'd0,   8'd0,   24'h000000}, 1'b1, 24'h010203},
    '{'{OP_SAMPLE, 16'hFEFF, 16'hFF80, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h0},
    '{'{OP_SAMPLE, 16'hFF01, 16'hFEFF, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h0},
    '{'{OP_WRITE,  16'h0000, 16'h0000, 8'd1,   8'd1,   24'hFFFFFF}, 1'b0, 24'h0},
    '{'{OP_SAMPLE, 16'h0000, 16'h0000, 8'd0,   8'd0,   24'h000000}, 1'b1, 24'h000000},
    '{'{OP_SAMPLE, 16'h00C0, 16'h0040, 8'd0,   8'd0,   24'h000000}, 1'b0, 24'h0}
  };

  bilinear_texture_sampler #(
    .TEX_DIM  (DIM),
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation),
    .u_coord_i    (u_coord),
    .v_coord_i    (v_coord),
    .write_x_i    (write_x),
    .write_y_i    (write_y),
    .texel_red_i  (texel_red),
    .texel_green_i(texel_green),
    .texel_blue_i (texel_blue),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Filter prediction
  // ---------------------------------------------------------------------------

  // One channel: exact weighted sum, then round half up to 8 bits.
  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] c00,
                                                   input logic [CHAN_W-1:0] c10,
                                                   input logic [CHAN_W-1:0] c01,
                                                   input logic [CHAN_W-1:0] c11,
                                                   input int unsigned fx,
                                                   input int unsigned fy);
    int unsigned acc;
    acc = c00 * (ONE - fx) * (ONE - fy) + c10 * fx * (ONE - fy)
        + c01 * (ONE - fx) * fy + c11 * fx * fy + (1 << (2 * FRAC - 1));
    return CHAN_W'(acc >> (2 * FRAC));
  endfunction

  function automatic int unsigned clamp_idx(input int unsigned i);
    return (i > DIM - 1) ? DIM - 1 : i;
  endfunction

  // Floor texel takes weight ONE-f, the clamped floor+1 neighbor takes f.
  function automatic rgb_t bilinear_color(input logic [COORD_W-1:0] u,
                                          input logic [COORD_W-1:0] v);
    int unsigned fx, fy, x0, y0, x1, y1;
    rgb_t t00, t10, t01, t11, res;
    fx  = 32'(u) & (ONE - 1);
    fy  = 32'(v) & (ONE - 1);
    x0  = clamp_idx(32'(u) >> FRAC);
    y0  = clamp_idx(32'(v) >> FRAC);
    x1  = clamp_idx(x0 + 1);
    y1  = clamp_idx(y0 + 1);
    t00 = texel_mem[y0 * DIM + x0];
    t10 = texel_mem[y0 * DIM + x1];
    t01 = texel_mem[y1 * DIM + x0];
    t11 = texel_mem[y1 * DIM + x1];
    res.r = blend_chan(t00.r, t10.r, t01.r, t11.r, fx, fy);
    res.g = blend_chan(t00.g, t10.g, t01.g, t11.g, fx, fy);
    res.b = blend_chan(t00.b, t10.b, t01.b, t11.b, fx, fy);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------

  // Entered and left at a falling edge. The word is booked into the shadow
  // texture, or its filtered color queued, at the edge that accepts it.
  task automatic send_word(input tex_word_t w, input bit known, input rgb_t want);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    operation   <= w.op;
    u_coord     <= w.u;
    v_coord     <= w.v;
    write_x     <= w.wx;
    write_y     <= w.wy;
    texel_red   <= w.color.r;
    texel_green <= w.color.g;
    texel_blue  <= w.color.b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    if (w.op == OP_WRITE) begin
      // out-of-range writes are dropped by the block
      if (w.wx < DIM && w.wy < DIM) begin
        texel_mem[w.wy * DIM + w.wx]     = w.color;
        texel_written[w.wy * DIM + w.wx] = 1'b1;
      end
    end else begin
      filtered_fifo.push_back(known ? want : bilinear_color(w.u, w.v));
    end
    @(negedge clk_i);
  endtask

  // Channel values lean on the extremes now and then.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  // Every field random; the caller fixes what matters for the operation.
  function automatic tex_word_t rand_word(input op_e op);
    tex_word_t w;
    w.op    = op;
    w.u     = COORD_W'($urandom_range(16'hFFFF));
    w.v     = COORD_W'($urandom_range(16'hFFFF));
    w.wx    = WR_IDX_W'($urandom_range(255));
    w.wy    = WR_IDX_W'($urandom_range(255));
    w.color = {rand_chan(), rand_chan(), rand_chan()};
    return w;
  endfunction

  task automatic fill_texel(input int unsigned x, input int unsigned y);
    tex_word_t w;
    w = rand_word(OP_WRITE);
    if (!texel_written[y * DIM + x]) begin
      w.wx = WR_IDX_W'(x);
      w.wy = WR_IDX_W'(y);
      send_word(w, 1'b0, '0);
    end
  endtask

  function automatic int unsigned pick_idx(input int unsigned prev);
    int unsigned i;
    case ($urandom_range(9))
      0:       i = 0;
      1:       i = DIM - 1;
      2:       i = DIM - 2;
      3, 4:    i = clamp_idx((prev == 0) ? $urandom_range(1) : prev - 1 + $urandom_range(2));
      default: i = $urandom_range(DIM - 1);
    endcase
    return i;
  endfunction

  function automatic int unsigned pick_frac();
    case ($urandom_range(7))
      0:       return 0;
      1:       return ONE - 1;
      default: return $urandom_range(ONE - 1);
    endcase
  endfunction

  // Well-formed sample: write whatever is missing of the 2x2 footprint,
  // then ask for the sample. Anchors often stay near the previous one so
  // later samples hit texels that are already there or overwritten.
  task automatic send_sample();
    tex_word_t   w;
    int unsigned x0, y0, x1, y1;
    x0 = pick_idx(last_x);
    y0 = pick_idx(last_y);
    x1 = clamp_idx(x0 + 1);
    y1 = clamp_idx(y0 + 1);
    fill_texel(x0, y0);
    fill_texel(x1, y0);
    fill_texel(x0, y1);
    fill_texel(x1, y1);
    w   = rand_word(OP_SAMPLE);
    w.u = COORD_W'((x0 << FRAC) | pick_frac());
    w.v = COORD_W'((y0 << FRAC) | pick_frac());
    send_word(w, 1'b0, '0);
    last_x = x0;
    last_y = y0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiving side and checks
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (filtered_fifo.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h%02h%02h", red_o, green_o, blue_o));
      end else begin
        head_rgb = filtered_fifo.pop_front();
        if (red_o !== head_rgb.r) begin
          report_mismatch($sformatf("result %0d red %02h, want %02h",
                                    results_seen, red_o, head_rgb.r));
        end
        if (green_o !== head_rgb.g) begin
          report_mismatch($sformatf("result %0d green %02h, want %02h",
                                    results_seen, green_o, head_rgb.g));
        end
        if (blue_o !== head_rgb.b) begin
          report_mismatch($sformatf("result %0d blue %02h, want %02h",
                                    results_seen, blue_o, head_rgb.b));
        end
      end
      results_seen++;
    end
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no word moved in %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    bit paused;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].want);
    end

    // Random mix: a quarter stray writes anywhere, the rest footprint-safe
    // samples. One window runs with no idling at all, and once the sender
    // holds off until every filtered color is back.
    while (words_sent < TOTAL_WORDS) begin
      steady = (words_sent >= 400 && words_sent < 650);
      if (!paused && words_sent >= 800) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk_i); while (filtered_fifo.size() != 0);
      end
      if ($urandom_range(3) == 0) begin
        send_word(rand_word(OP_WRITE), 1'b0, '0);
      end else begin
        send_sample();
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (filtered_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bts_pkg.sv
hw/rtl/bts_front.sv
hw/rtl/bts_queue.sv
hw/rtl/bts_back.sv
hw/rtl/bilinear_texture_sampler.sv
bench/bilinear_texture_sampler_tb.sv
